@@ src/gated_nearest_landmark_match_defines.svh @@
// assertion macros used by the file that checks internal behavior
`ifndef GATED_NEAREST_LANDMARK_MATCH_DEFINES_SVH
`define GATED_NEAREST_LANDMARK_MATCH_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define GNLM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GNLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/gnlm_pkg.sv @@
`default_nettype none

package gnlm_pkg;

    // table geometry
    localparam int MAX_LANDMARKS = 64;
    localparam int ADDR_W        = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int COUNT_W       = 7;

    // field widths
    localparam int POS_W   = 24;
    localparam int ID_W    = 16;
    localparam int SLOT_W  = 6;
    localparam int WGT_W   = 24;
    localparam int THR_W   = 32;
    localparam int MAG_W   = POS_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SAT_W   = 48;
    localparam int DIST_W  = SQ_W + 1;
    localparam int ENTRY_W = ID_W + 2 * POS_W;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [WGT_W-1:0] INV_VAR_RESET = 24'd65536;
    localparam logic [THR_W-1:0] GATE_RESET    = 32'd603586;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GATING_ENABLE  = 3'd0,
        CFG_INV_VAR_X      = 3'd1,
        CFG_INV_VAR_Y      = 3'd2,
        CFG_GATE_THRESHOLD = 3'd3,
        CFG_LANDMARK_COUNT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic                    mode;
        logic [SLOT_W-1:0]       slot;
        logic [ID_W-1:0]         landmark_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0] matched_id;
        logic            matched;
    } out_item_t;

    typedef struct packed {
        logic                    is_query;
        logic [SLOT_W-1:0]       slot;
        logic [ID_W-1:0]         landmark_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } cmd_t;

    typedef struct packed {
        logic               gating_enable;
        logic [WGT_W-1:0]   inv_var_x;
        logic [WGT_W-1:0]   inv_var_y;
        logic [THR_W-1:0]   gate_threshold;
        logic [COUNT_W-1:0] landmark_count;
    } cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } entry_t;

endpackage

`default_nettype wire

@@ src/gnlm_ram.sv @@
`default_nettype none

module gnlm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                            clk,
    input  wire logic                                            wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0]                                wr_data,
    input  wire logic                                            rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
    output logic      [WIDTH-1:0]                                rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/gnlm_front.sv @@
`default_nettype none

module gnlm_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire gnlm_pkg::in_item_t item,
    output logic                   cmd_valid,
    input  wire logic              cmd_pop,
    output gnlm_pkg::cmd_t         cmd
);

    import gnlm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;
    cmd_t             new_cmd;

    // classify: mode selects load or query
    always_comb
    begin
        new_cmd.is_query    = item.mode;
        new_cmd.slot        = item.slot;
        new_cmd.landmark_id = item.landmark_id;
        new_cmd.pos_x       = item.pos_x;
        new_cmd.pos_y       = item.pos_y;
    end

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;
    assign cmd       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

@@ src/gnlm_back.sv @@
`default_nettype none

module gnlm_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire gnlm_pkg::cfg_t  cfg,
    input  wire logic            cmd_valid,
    input  wire gnlm_pkg::cmd_t  cmd,
    output logic                 cmd_pop,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output gnlm_pkg::out_item_t  res
);

    import gnlm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic [ADDR_W-1:0]       last_idx_reg, last_idx_next;
    logic signed [POS_W-1:0] obs_x_reg, obs_x_next;
    logic signed [POS_W-1:0] obs_y_reg, obs_y_next;
    logic [COUNT_W-1:0]      n_lim;
    logic                    slot_ok;

    // table port
    logic              ram_wr_en, ram_rd_en;
    logic [ENTRY_W-1:0] ram_rd_data;
    entry_t             wr_entry, rd_entry;

    // scan pipeline
    logic p1_valid_reg, p1_valid_next, p1_last_reg, p1_last_next;
    logic p2_valid_reg, p2_last_reg;
    logic p3_valid_reg, p3_last_reg;
    logic p4_valid_reg, p4_last_reg;
    logic p5_valid_reg, p5_last_reg;

    logic signed [POS_W:0] dx, dy;
    logic [POS_W:0]        abs_dx, abs_dy;
    logic [MAG_W-1:0]      p2_mag_x_reg, p2_mag_y_reg;
    logic [ID_W-1:0]       p2_id_reg, p3_id_reg, p4_id_reg, p5_id_reg;
    logic [SQ_W-1:0]       p3_sq_x_reg, p3_sq_y_reg;
    logic [SQ_W-1:0]       p4_sq_x_reg, p4_sq_y_reg;
    logic [SQ_W-1:0]       p4_hi_x_reg, p4_lo_x_reg, p4_hi_y_reg, p4_lo_y_reg;
    logic [SQ_W+8:0]       wx, wy;
    logic [SAT_W-1:0]      sat_x, sat_y;
    logic [SAT_W:0]        wsum;
    logic [DIST_W-1:0]     metric;
    logic [DIST_W-1:0]     p5_dist_reg;

    // running minimum
    logic              found_reg, found_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic [ID_W-1:0]   best_id_reg, best_id_next;
    logic              clear_best;
    logic              matched;

    assign n_lim   = (cfg.landmark_count > COUNT_W'(MAX_LANDMARKS)) ?
                     COUNT_W'(MAX_LANDMARKS) : cfg.landmark_count;
    assign slot_ok = ({1'b0, cmd.slot} < COUNT_W'(MAX_LANDMARKS));

    assign wr_entry.id = cmd.landmark_id;
    assign wr_entry.x  = cmd.pos_x;
    assign wr_entry.y  = cmd.pos_y;
    assign rd_entry    = entry_t'(ram_rd_data);

    gnlm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LANDMARKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ADDR_W'(cmd.slot)),
        .wr_data (wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        obs_x_next    = obs_x_reg;
        obs_y_next    = obs_y_reg;
        cmd_pop       = 1'b0;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;
        p1_valid_next = 1'b0;
        p1_last_next  = 1'b0;
        res_valid     = 1'b0;
        clear_best    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (!cmd.is_query)
                    begin
                        ram_wr_en = slot_ok;
                    end
                    else
                    begin
                        obs_x_next = cmd.pos_x;
                        obs_y_next = cmd.pos_y;
                        clear_best = 1'b1;
                        idx_next   = '0;
                        if (n_lim == '0)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            last_idx_next = ADDR_W'(n_lim - 1'b1);
                            state_next    = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                ram_rd_en     = 1'b1;
                p1_valid_next = 1'b1;
                p1_last_next  = (idx_reg == last_idx_reg);
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == last_idx_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (p5_valid_reg && p5_last_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // p1: differences against the table entry just read
    always_comb
    begin
        dx     = $signed({obs_x_reg[POS_W-1], obs_x_reg}) -
                 $signed({rd_entry.x[POS_W-1], rd_entry.x});
        dy     = $signed({obs_y_reg[POS_W-1], obs_y_reg}) -
                 $signed({rd_entry.y[POS_W-1], rd_entry.y});
        abs_dx = dx[POS_W] ? (POS_W+1)'(-dx) : dx;
        abs_dy = dy[POS_W] ? (POS_W+1)'(-dy) : dy;
    end

    // p4 -> p5: weigh, saturate and pick the metric
    always_comb
    begin
        wx    = {p4_hi_x_reg, 8'b0} + (SQ_W+9)'(p4_lo_x_reg >> 16);
        wy    = {p4_hi_y_reg, 8'b0} + (SQ_W+9)'(p4_lo_y_reg >> 16);
        sat_x = (wx[SQ_W+8:SAT_W] != '0) ? '1 : wx[SAT_W-1:0];
        sat_y = (wy[SQ_W+8:SAT_W] != '0) ? '1 : wy[SAT_W-1:0];
        wsum  = {1'b0, sat_x} + {1'b0, sat_y};
        if (cfg.gating_enable)
        begin
            metric = DIST_W'(wsum[SAT_W] ? {SAT_W{1'b1}} : wsum[SAT_W-1:0]);
        end
        else
        begin
            metric = {1'b0, p4_sq_x_reg} + {1'b0, p4_sq_y_reg};
        end
    end

    // running minimum, first entry wins on ties
    always_comb
    begin
        found_next   = found_reg;
        best_next    = best_reg;
        best_id_next = best_id_reg;
        if (clear_best)
        begin
            found_next = 1'b0;
        end
        else if (p5_valid_reg && (!found_reg || (p5_dist_reg < best_reg)))
        begin
            found_next   = 1'b1;
            best_next    = p5_dist_reg;
            best_id_next = p5_id_reg;
        end
    end

    assign matched = found_reg &&
                     (!cfg.gating_enable || (best_reg < DIST_W'(cfg.gate_threshold)));
    assign res.matched    = matched;
    assign res.matched_id = matched ? best_id_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            last_idx_reg <= '0;
            p1_valid_reg <= 1'b0;
            p1_last_reg  <= 1'b0;
            p2_valid_reg <= 1'b0;
            p2_last_reg  <= 1'b0;
            p3_valid_reg <= 1'b0;
            p3_last_reg  <= 1'b0;
            p4_valid_reg <= 1'b0;
            p4_last_reg  <= 1'b0;
            p5_valid_reg <= 1'b0;
            p5_last_reg  <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            last_idx_reg <= last_idx_next;
            p1_valid_reg <= p1_valid_next;
            p1_last_reg  <= p1_last_next;
            p2_valid_reg <= p1_valid_reg;
            p2_last_reg  <= p1_last_reg;
            p3_valid_reg <= p2_valid_reg;
            p3_last_reg  <= p2_last_reg;
            p4_valid_reg <= p3_valid_reg;
            p4_last_reg  <= p3_last_reg;
            p5_valid_reg <= p4_valid_reg;
            p5_last_reg  <= p4_last_reg;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obs_x_reg    <= obs_x_next;
        obs_y_reg    <= obs_y_next;
        best_reg     <= best_next;
        best_id_reg  <= best_id_next;
        // p2: magnitudes
        p2_mag_x_reg <= abs_dx[MAG_W-1:0];
        p2_mag_y_reg <= abs_dy[MAG_W-1:0];
        p2_id_reg    <= rd_entry.id;
        // p3: squares
        p3_sq_x_reg  <= p2_mag_x_reg * p2_mag_x_reg;
        p3_sq_y_reg  <= p2_mag_y_reg * p2_mag_y_reg;
        p3_id_reg    <= p2_id_reg;
        // p4: split weighting products
        p4_hi_x_reg  <= p3_sq_x_reg[SQ_W-1:MAG_W] * cfg.inv_var_x;
        p4_lo_x_reg  <= p3_sq_x_reg[MAG_W-1:0] * cfg.inv_var_x;
        p4_hi_y_reg  <= p3_sq_y_reg[SQ_W-1:MAG_W] * cfg.inv_var_y;
        p4_lo_y_reg  <= p3_sq_y_reg[MAG_W-1:0] * cfg.inv_var_y;
        p4_sq_x_reg  <= p3_sq_x_reg;
        p4_sq_y_reg  <= p3_sq_y_reg;
        p4_id_reg    <= p3_id_reg;
        // p5: distance
        p5_dist_reg  <= metric;
        p5_id_reg    <= p4_id_reg;
    end

endmodule

`default_nettype wire

@@ src/gated_nearest_landmark_match.sv @@
`default_nettype none

// Nearest-landmark association with an optional weighted gate. Load items
// (mode 0) store id and Q15.8 position into a 64-entry table held in one
// single-port-read RAM; query items (mode 1) return exactly one result with
// the id of the closest of the first landmark_count entries, lowest slot
// first on ties. With gating_enable clear the metric is dx^2 + dy^2 and any
// non-empty table matches; with it set the metric is the sum weighted by the
// Q8.16 inv_var values, saturated to 48 bits, and a match needs it strictly
// below gate_threshold. Loads produce no result. Timing: a front queue of two
// entries takes items while the back works. A load is written to the table as
// it is popped. A query occupies the back for a scan in which the table RAM
// delivers one entry per cycle, then a five-register distance pipeline, then
// posting the result once the output register is free; an empty table skips
// the scan. Results wait in an output register, so the queue keeps
// filling while a result is not yet popped. Reading a slot that was never
// loaded gives an undefined id. Configuration is written through the cfg
// channel, which is always ready, and must only change while the block is idle.

`include "gated_nearest_landmark_match_defines.svh"

module gated_nearest_landmark_match (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input queue side
    input  wire logic                                 push,
    output logic                                      full,
    input  wire gnlm_pkg::in_item_t                   item,
    // result queue side
    output logic                                      empty,
    input  wire logic                                 pop,
    output gnlm_pkg::out_item_t                       result,
    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [gnlm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [gnlm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import gnlm_pkg::*;

    // configuration registers
    cfg_t      cfg_reg, cfg_next;

    // front to back command transaction
    logic      cmd_valid;
    logic      cmd_pop;
    cmd_t      cmd;

    // back to output register
    logic      res_valid;
    logic      res_ready;
    out_item_t res;

    // output register
    logic      out_valid_reg, out_valid_next;
    out_item_t result_reg;

    // config writes are always accepted and registered
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GATING_ENABLE:  cfg_next.gating_enable  = cfg_data[0];
                CFG_INV_VAR_X:      cfg_next.inv_var_x      = cfg_data[WGT_W-1:0];
                CFG_INV_VAR_Y:      cfg_next.inv_var_y      = cfg_data[WGT_W-1:0];
                CFG_GATE_THRESHOLD: cfg_next.gate_threshold = cfg_data[THR_W-1:0];
                CFG_LANDMARK_COUNT: cfg_next.landmark_count = cfg_data[COUNT_W-1:0];
                // indexes beyond the list are dropped
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gating_enable  <= 1'b0;
            cfg_reg.inv_var_x      <= INV_VAR_RESET;
            cfg_reg.inv_var_y      <= INV_VAR_RESET;
            cfg_reg.gate_threshold <= GATE_RESET;
            cfg_reg.landmark_count <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accepts and classifies items into the command queue
    gnlm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // back: table writes and the nearest-entry scan
    gnlm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // one-entry result register, refilled in the same cycle it is popped
    assign res_ready = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            result_reg <= res;
        end
    end

    // a full queue always offers a command to the back
    `GNLM_ASSERT_SAME(a_full_has_cmd, full, cmd_valid, "queue full but no command offered")
    // the back only takes a command that is there
    `GNLM_ASSERT_SAME(a_pop_needs_cmd, cmd_pop, cmd_valid, "command popped from empty queue")
    // a new result never overwrites one still waiting
    `GNLM_ASSERT_SAME(a_res_slot_free, res_valid, empty || pop, "result register overwritten")
    // a posted result shows up on the result side next cycle
    `GNLM_ASSERT_NEXT(a_res_visible, res_valid, !empty, "posted result not visible")
    // no match always reports id zero
    `GNLM_ASSERT_SAME(a_nomatch_zero_id, !empty && !result.matched, result.matched_id == '0,
        "unmatched result carries an id")

endmodule

`default_nettype wire
